// ===== sv/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/rau_pkg.sv =====
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants
// Field widths, command codes and the queued item record.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int DEN_BITS     = OPERAND_BITS - 1;
    localparam int WORK_BITS    = 2 * OPERAND_BITS + 1;
    localparam int OUT_NUM_BITS = 32;
    localparam int OUT_DEN_BITS = 31;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = 1;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_CMP = 2'd3
    } command_t;

    typedef struct packed {
        command_t                    command;
        logic signed [OPERAND_BITS-1:0] a_num;
        logic [DEN_BITS-1:0]         a_den;
        logic signed [OPERAND_BITS-1:0] b_num;
        logic [DEN_BITS-1:0]         b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_NUM_BITS-1:0] result_num;
        logic [OUT_DEN_BITS-1:0]     result_den;
        logic                        is_greater;
    } out_item_t;

    // Classified item passed from front to back
    typedef struct packed {
        in_item_t item;
        logic     bad_den;
    } job_t;

    typedef struct packed {
        logic busy;
        logic out_pending;
    } back_status_t;

endpackage

// ===== sv/rau_stream_if.sv =====
// ---------------------------------------------------------------------------
// rau_in_if / rau_out_if: valid/ready channels
// Input channel carries operands, output channel carries results.
// ---------------------------------------------------------------------------
interface rau_in_if;
    logic             valid;
    logic             ready;
    rau_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rau_out_if;
    logic              valid;
    logic              ready;
    rau_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rau_front.sv =====
// ---------------------------------------------------------------------------
// rau_front: intake and queue
// Accepts items, flags zero denominators, and buffers them in a short queue.
// ---------------------------------------------------------------------------
module rau_front (
    input  logic           clk,
    input  logic           rst_n,
    rau_in_if.sink         in_ch,
    output logic           job_valid,
    output rau_pkg::job_t  job,
    input  logic           job_take
);

    rau_pkg::job_t             q_mem [rau_pkg::QUEUE_DEPTH];
    logic [rau_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [rau_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic push, pop;
    rau_pkg::job_t new_job;

    // classification
    always_comb
    begin
        new_job.item    = in_ch.data;
        new_job.bad_den = (in_ch.data.a_den == '0) || (in_ch.data.b_den == '0);
    end

    assign in_ch.ready = (count_reg != rau_pkg::QUEUE_DEPTH[rau_pkg::QUEUE_AW:0]);
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = job_take && job_valid;
    assign job_valid = (count_reg != '0);
    assign job = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{rau_pkg::QUEUE_AW{1'b0}}, push}
                      - {{rau_pkg::QUEUE_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "rational_arithmetic_unit_assert.svh"
    `RAU_ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1,
        count_reg <= rau_pkg::QUEUE_DEPTH[rau_pkg::QUEUE_AW:0])
    `RAU_ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `RAU_ASSERT_NEXT(a_pop_counts, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== sv/rau_back.sv =====
// ---------------------------------------------------------------------------
// rau_back: sequenced arithmetic engine
// A shared multiplier and one radix-2 divider serve the steps of each item; idle loads and compares multiply apart.
// ---------------------------------------------------------------------------
module rau_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  rau_pkg::job_t        job,
    output logic                 job_take,
    rau_out_if.source            out_ch,
    output rau_pkg::back_status_t status
);

    localparam int W  = rau_pkg::WORK_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int MW = rau_pkg::OPERAND_BITS + 1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_GCD1  = 12'b000000000010, // gcd(ad,bd)
        S_DIVL  = 12'b000000000100, // ad / g  -> fa, bd / g -> fb
        S_DIVL2 = 12'b000000001000,
        S_MUL1  = 12'b000000010000, // an * fb
        S_MUL2  = 12'b000000100000, // bn * fa
        S_MUL3  = 12'b000001000000, // lcm = ad * fb
        S_GCD2  = 12'b000010000000, // gcd(|n|, d)
        S_RDN   = 12'b000100000000, // |n| / g
        S_RDD   = 12'b001000000000, // d / g
        S_DONE  = 12'b010000000000,
        S_DIVW  = 12'b100000000000  // divider busy
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    rau_pkg::in_item_t it_reg;
    logic [W-1:0] x_reg, y_reg, fa_reg, fb_reg, d_reg, g_reg;
    logic signed [W:0] n_reg, ta_reg;
    logic neg_reg;
    rau_pkg::out_item_t res_reg;
    logic out_valid_reg;

    // divider: quotient/remainder of dvd_reg / dvs_reg, one bit a cycle
    logic [W-1:0] dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0] trial;
    logic div_start;
    logic [W-1:0] div_a, div_b;

    // multiplier operands (17 x 17 signed), product
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] prod;

    assign prod = mul_a * mul_b;
    assign trial = {rem_reg, dvd_reg[W-1]} - {1'b0, dvs_reg};
    assign job_take = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = res_reg;
    assign status.busy = (state_reg != S_IDLE);
    assign status.out_pending = out_valid_reg;

    logic [W-1:0] absn;
    assign absn = n_reg[W] ? W'(-n_reg) : n_reg[W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '1;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            S_MUL1:
            begin
                mul_a = MW'(it_reg.a_num);
                mul_b = $signed({1'b0, fb_reg[MW-2:0]});
            end
            S_MUL2:
            begin
                mul_a = MW'(it_reg.b_num);
                mul_b = $signed({1'b0, fa_reg[MW-2:0]});
            end
            S_MUL3:
            begin
                mul_a = $signed({2'b00, it_reg.a_den});
                mul_b = $signed({1'b0, fb_reg[MW-2:0]});
            end
            default:
            begin
                mul_a = MW'(it_reg.a_num);
                mul_b = MW'(it_reg.b_num);
            end
        endcase
        case (state_reg)
            S_IDLE:
            begin
                if (job_take && job_valid)
                begin
                    if (job.item.command == rau_pkg::CMD_CMP || job.bad_den)
                        state_next = S_IDLE;
                    else if (job.item.command == rau_pkg::CMD_MUL)
                        state_next = S_MUL3;
                    else
                        state_next = S_GCD1;
                end
            end
            S_GCD1, S_GCD2:
            begin
                if (y_reg != '0)
                begin
                    div_start = 1'b1;
                    div_a = x_reg;
                    div_b = y_reg;
                    ret_next = state_reg;
                    state_next = S_DIVW;
                end
                else
                begin
                    state_next = (state_reg == S_GCD1) ? S_DIVL : S_RDN;
                end
            end
            S_DIVL:
            begin
                div_start = 1'b1; div_a = W'(it_reg.a_den); div_b = g_reg;
                ret_next = S_DIVL; state_next = S_DIVW;
            end
            S_DIVL2:
            begin
                div_start = 1'b1; div_a = W'(it_reg.b_den); div_b = g_reg;
                ret_next = S_DIVL2; state_next = S_DIVW;
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3: state_next = S_GCD2;
            S_RDN:
            begin
                div_start = 1'b1; div_a = absn; div_b = g_reg;
                ret_next = S_RDN; state_next = S_DIVW;
            end
            S_RDD:
            begin
                div_start = 1'b1; div_a = d_reg; div_b = g_reg;
                ret_next = S_RDD; state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (cnt_reg == '0)
                begin
                    case (ret_reg)
                        S_GCD1: state_next = S_GCD1;
                        S_GCD2: state_next = S_GCD2;
                        S_DIVL: state_next = S_DIVL2;
                        S_DIVL2: state_next = S_MUL1;
                        S_RDN: state_next = S_RDD;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DONE: state_next = S_IDLE;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dvd_reg <= div_a;
            dvs_reg <= div_b;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (state_reg == S_DIVW && cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], dvd_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
        if (state_reg == S_DIVW && cnt_reg == '0)
        begin
            case (ret_reg)
                S_GCD1, S_GCD2:
                begin
                    x_reg <= y_reg;
                    y_reg <= rem_reg;
                    g_reg <= y_reg;
                end
                S_DIVL: fa_reg <= quo_reg;
                S_DIVL2: fb_reg <= quo_reg;
                S_RDN: n_reg <= neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
                default: d_reg <= quo_reg;
            endcase
        end
        case (state_reg)
            S_IDLE:
            begin
                // load operands; multiply uses the product of numerators and bd as fb
                it_reg <= job.item;
                x_reg  <= W'(job.item.a_den);
                y_reg  <= W'(job.item.b_den);
                g_reg  <= W'(job.item.a_den);
                fb_reg <= W'(job.item.b_den);
                n_reg  <= (W+1)'($signed(job.item.a_num) * $signed(job.item.b_num));
            end
            S_MUL1: ta_reg <= (W+1)'(prod);
            S_MUL2:
            begin
                n_reg <= (it_reg.command == rau_pkg::CMD_ADD) ? ta_reg + (W+1)'(prod)
                                                              : ta_reg - (W+1)'(prod);
            end
            S_MUL3:
            begin
                d_reg <= W'(prod);
                x_reg <= absn;
                y_reg <= W'(prod);
                neg_reg <= n_reg[W];
            end
            default: ;
        endcase
        if (state_reg == S_DONE)
        begin
            res_reg.is_greater <= 1'b0;
            if (n_reg == '0)
            begin
                res_reg.result_num <= '0;
                res_reg.result_den <= rau_pkg::OUT_DEN_BITS'(1);
            end
            else
            begin
                res_reg.result_num <= rau_pkg::OUT_NUM_BITS'(n_reg);
                res_reg.result_den <= rau_pkg::OUT_DEN_BITS'(d_reg);
            end
        end
        if (state_reg == S_IDLE && job_take && job_valid)
        begin
            if (job.item.command == rau_pkg::CMD_CMP)
            begin
                res_reg.result_num <= '0;
                res_reg.result_den <= '0;
                res_reg.is_greater <=
                    ((W+1)'($signed(job.item.a_num) * $signed({1'b0, job.item.b_den})))
                    > ((W+1)'($signed(job.item.b_num) * $signed({1'b0, job.item.a_den})));
            end
            else if (job.bad_den)
            begin
                res_reg <= '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (div_start)
                cnt_reg <= CW'(W);
            else if (state_reg == S_DIVW && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            if (state_reg == S_IDLE && job_take && job_valid)
            begin
                if (job.item.command == rau_pkg::CMD_CMP || job.bad_den)
                    out_valid_reg <= 1'b1;
            end
        end
    end

`include "rational_arithmetic_unit_assert.svh"
    `RAU_ASSERT_IMPL(a_take_idle, clk, rst_n, job_take, state_reg == S_IDLE && !out_valid_reg)
    `RAU_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, out_valid_reg)
    `RAU_ASSERT_IMPL(a_div_ret, clk, rst_n, state_reg == S_DIVW, ret_reg != S_IDLE)

endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/compare with gcd reduction
// Front intake with a two-entry queue feeding a sequenced arithmetic back end.
// ---------------------------------------------------------------------------
//  channel   dir   payload
//  in_ch     in    command, a_num, a_den, b_num, b_den
//  out_ch    out   result_num, result_den, is_greater
//
// Compare and zero-denominator items are answered in the cycle after the back end takes them.
// Each divide or Euclid step runs on the bit-serial divider: issue, shifts, writeback.
// Add/sub needs two gcds and four divides; multiply needs one gcd and two divides.
// The number of Euclid steps in each gcd depends on the operands.
// The divider is the pacing unit. Reset clears queue pointers and sequencer.
// Output stalls hold the back end; the front keeps queuing up to two items.
module rational_arithmetic_unit (
    input  logic  clk,
    input  logic  rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);

    logic          job_valid, job_take;
    rau_pkg::job_t job;
    rau_pkg::back_status_t status;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .job_valid(job_valid), .job(job), .job_take(job_take)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_take(job_take), .out_ch(out_ch), .status(status)
    );

`include "rational_arithmetic_unit_assert.svh"
    `RAU_ASSERT_IMPL(a_out_from_back, clk, rst_n, out_ch.valid, status.out_pending)
    `RAU_ASSERT_IMPL(a_take_quiet, clk, rst_n, job_take, !status.busy)
    `RAU_ASSERT_NEXT(a_hold_out, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: rational arithmetic unit
// Drives fraction add/sub/mul/compare items through a directed table and
// then random operands, with random gaps on both channels. Every result is
// checked field by field against an in-order queue of predicted results.
// ---------------------------------------------------------------------------
module testbench;

    localparam int  RANDOM_ITEMS = 1030;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int  DRAIN_CYCLES = 600;

    typedef struct {
        rau_pkg::in_item_t  item;
        bit                 typed;
        rau_pkg::out_item_t answer;
    } row_t;

    logic clk;
    logic rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    rau_pkg::out_item_t pending_results[$];
    rau_pkg::out_item_t next_answer;
    row_t      rows[$];
    int        taken_count;
    int        error_count;
    longint    cycle_count;
    bit        no_gaps;
    bit        done;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Greatest common divisor, Euclid
    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce n/d by the gcd; zero numerator gives 0/1
    function automatic rau_pkg::out_item_t reduce_fraction(longint n, longint unsigned d);
        rau_pkg::out_item_t r;
        longint unsigned g;
        longint unsigned mag;
        r = '0;
        if (n == 0)
        begin
            r.result_den = rau_pkg::OUT_DEN_BITS'(1);
            return r;
        end
        mag = (n < 0) ? longint'(-n) : longint'(n);
        g = gcd_of(mag, d);
        r.result_num = rau_pkg::OUT_NUM_BITS'(n / longint'(g));
        r.result_den = rau_pkg::OUT_DEN_BITS'(d / g);
        return r;
    endfunction

    // Predicted result of one item
    function automatic rau_pkg::out_item_t fraction_result(rau_pkg::in_item_t it);
        rau_pkg::out_item_t r;
        longint an, bn, ta, tb;
        longint unsigned ad, bd, lcm, g;
        r  = '0;
        an = longint'(it.a_num);
        bn = longint'(it.b_num);
        ad = 64'(it.a_den);
        bd = 64'(it.b_den);
        if (it.command == rau_pkg::CMD_CMP)
        begin
            r.is_greater = (an * longint'(bd)) > (bn * longint'(ad));
            return r;
        end
        if (ad == 0 || bd == 0)
            return r;
        if (it.command == rau_pkg::CMD_MUL)
            return reduce_fraction(an * bn, ad * bd);
        g   = gcd_of(ad, bd);
        lcm = (ad / g) * bd;
        ta  = an * longint'(lcm / ad);
        tb  = bn * longint'(lcm / bd);
        return reduce_fraction((it.command == rau_pkg::CMD_ADD) ? ta + tb : ta - tb, lcm);
    endfunction

    function automatic rau_pkg::in_item_t make_item(rau_pkg::command_t c, int an, int ad,
                                                    int bn, int bd);
        rau_pkg::in_item_t it;
        it.command = c;
        it.a_num   = rau_pkg::OPERAND_BITS'(an);
        it.a_den   = rau_pkg::DEN_BITS'(ad);
        it.b_num   = rau_pkg::OPERAND_BITS'(bn);
        it.b_den   = rau_pkg::DEN_BITS'(bd);
        return it;
    endfunction

    task automatic add_row(rau_pkg::in_item_t it, bit typed, int n = 0, int d = 0,
                           bit gt = 0);
        row_t r;
        r.item  = it;
        r.typed = typed;
        r.answer.result_num = n;
        r.answer.result_den = rau_pkg::OUT_DEN_BITS'(d);
        r.answer.is_greater = gt;
        rows.push_back(r);
    endtask

    // Random operand value, often small so reductions happen
    function automatic int rand_num();
        case ($urandom_range(3))
            0: return $signed(16'($urandom));
            1: return int'($urandom_range(64)) - 32;
            2: return ($urandom_range(1)) ? 32767 : -32768;
            default: return $signed(16'($urandom)) >>> $urandom_range(14);
        endcase
    endfunction

    function automatic int rand_den();
        case ($urandom_range(5))
            0: return $urandom_range(32767);
            1: return $urandom_range(1) ? 32767 : $urandom_range(1);
            2: return 15'($urandom) >> $urandom_range(14);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // Send one item, holding valid until it is taken
    task automatic send_item(rau_pkg::in_item_t it, rau_pkg::out_item_t answer);
        int seen;
        while (!no_gaps && $urandom_range(99) < 38)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        seen        = taken_count;
        next_answer = answer;
        in_ch.data  = it;
        in_ch.valid = 1'b1;
        do
            @(negedge clk);
        while (taken_count == seen);
        in_ch.valid = 1'b0;
    endtask

    // Output ready with random stalls
    always @(negedge clk)
    begin
        out_ch.ready = no_gaps ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // Accept items and check results
    always @(posedge clk)
    begin
        rau_pkg::out_item_t want;
        rau_pkg::out_item_t got;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            pending_results.push_back(next_answer);
            taken_count = taken_count + 1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result num=%0d den=%0d gt=%0d", $time,
                         got.result_num, got.result_den, got.is_greater);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.result_num !== want.result_num)
                begin
                    $display("%0t: result_num expected %0d actual %0d", $time,
                             want.result_num, got.result_num);
                    error_count = error_count + 1;
                end
                if (got.result_den !== want.result_den)
                begin
                    $display("%0t: result_den expected %0d actual %0d", $time,
                             want.result_den, got.result_den);
                    error_count = error_count + 1;
                end
                if (got.is_greater !== want.is_greater)
                begin
                    $display("%0t: is_greater expected %0d actual %0d", $time,
                             want.is_greater, got.is_greater);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT && !done)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        rau_pkg::in_item_t it;
        row_t     r;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        next_answer  = '0;
        taken_count  = 0;
        error_count  = 0;
        cycle_count  = 0;
        no_gaps      = 1'b0;
        done         = 1'b0;
        rst_n        = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: zero results, invalid denominators, compares, extremes
        add_row(make_item(rau_pkg::CMD_ADD, 0, 1, 0, 1), 1, 0, 1);
        add_row(make_item(rau_pkg::CMD_SUB, 5, 3, 5, 3), 1, 0, 1);
        add_row(make_item(rau_pkg::CMD_MUL, 0, 7, -9, 4), 1, 0, 1);
        add_row(make_item(rau_pkg::CMD_ADD, 3, 0, 1, 2), 1, 0, 0);
        add_row(make_item(rau_pkg::CMD_SUB, 3, 5, 1, 0), 1, 0, 0);
        add_row(make_item(rau_pkg::CMD_MUL, 3, 0, 1, 0), 1, 0, 0);
        add_row(make_item(rau_pkg::CMD_CMP, 1, 2, 1, 3), 1, 0, 0, 1);
        add_row(make_item(rau_pkg::CMD_CMP, 2, 4, 1, 2), 1, 0, 0, 0);
        add_row(make_item(rau_pkg::CMD_CMP, 5, 0, 3, 0), 1, 0, 0, 0);
        add_row(make_item(rau_pkg::CMD_MUL, -32768, 1, -32768, 1), 1, 1073741824, 1);
        add_row(make_item(rau_pkg::CMD_MUL, 32767, 32767, 32767, 32767), 1, 1, 1);
        add_row(make_item(rau_pkg::CMD_ADD, 32767, 1, 32767, 1), 1, 65534, 1);
        add_row(make_item(rau_pkg::CMD_SUB, -32768, 1, 32767, 1), 1, -65535, 1);
        add_row(make_item(rau_pkg::CMD_CMP, -32768, 1, 32767, 1), 1, 0, 0, 0);
        add_row(make_item(rau_pkg::CMD_CMP, 32767, 1, -32768, 1), 1, 0, 0, 1);
        add_row(make_item(rau_pkg::CMD_SUB, 1, 2, 1, 3), 1, 1, 6);
        add_row(make_item(rau_pkg::CMD_ADD, -1, 2, 1, 3), 1, -1, 6);
        add_row(make_item(rau_pkg::CMD_ADD, 1, 32767, 1, 32766), 0);
        add_row(make_item(rau_pkg::CMD_MUL, -32768, 32767, 32767, 1), 0);
        add_row(make_item(rau_pkg::CMD_SUB, -32768, 32767, 32767, 32766), 0);
        add_row(make_item(rau_pkg::CMD_CMP, -32768, 32767, -32768, 32766), 0);
        foreach (rows[i])
        begin
            r = rows[i];
            send_item(r.item, r.typed ? r.answer : fraction_result(r.item));
        end

        // Random items
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= 300 && n < 450);
            if (n == 700)
            begin
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            it.command = rau_pkg::command_t'($urandom_range(3));
            it.a_num   = rau_pkg::OPERAND_BITS'(rand_num());
            it.a_den   = rau_pkg::DEN_BITS'(rand_den());
            it.b_num   = rau_pkg::OPERAND_BITS'(rand_num());
            it.b_den   = rau_pkg::DEN_BITS'(rand_den());
            send_item(it, fraction_result(it));
        end

        // Drain
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        done = 1'b1;
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
